// ===== sv/axis_angle_matrix_rotation_core_macros.svh =====
// Assertion macros shared by the rotation core RTL.
// Needs a clk and an active-low rst_n in the including module's scope.
`ifndef AXIS_ANGLE_MATRIX_ROTATION_CORE_MACROS_SVH
`define AXIS_ANGLE_MATRIX_ROTATION_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AAMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AAMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/aamr_pkg.sv =====
// Types, constants and tables of the axis-angle rotation core.
// No dependencies.
package aamr_pkg;

    localparam int OPW           = 34;
    localparam int SQRT_ITERS    = 31;
    localparam int DIV_ITERS     = 32;
    localparam int CORDIC_STEPS  = 30;
    localparam int MAC_LAST      = 23;
    localparam int MAC_FIRST_MAT = 3;

    typedef logic signed [OPW-1:0] op_t;

    localparam op_t Q30_ONE      = 34'sd1073741824;
    localparam op_t CORDIC_START = 34'sd652032874;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LEN    = 6'b000010,
        S_SQRT   = 6'b000100,
        S_DIV    = 6'b001000,
        S_CORDIC = 6'b010000,
        S_MAT    = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_mode_t;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_LEN,
        DST_PAIR,
        DST_MAT
    } dest_t;

    typedef struct packed {
        op_t       a;
        op_t       b;
        acc_mode_t mode;
        dest_t     dest;
        logic [3:0] idx;
        op_t       base;
    } mac_ctl_t;

    localparam logic [1:0] CFG_AXIS_X = 2'd0;
    localparam logic [1:0] CFG_AXIS_Y = 2'd1;
    localparam logic [1:0] CFG_AXIS_Z = 2'd2;
    localparam logic [1:0] CFG_ANGLE  = 2'd3;

    function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
        logic signed [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'sh20000000;
                5'd1:  r = 32'sh12E4051E;
                5'd2:  r = 32'sh09FB385B;
                5'd3:  r = 32'sh051111D4;
                5'd4:  r = 32'sh028B0D43;
                5'd5:  r = 32'sh0145D7E1;
                5'd6:  r = 32'sh00A2F61E;
                5'd7:  r = 32'sh00517C55;
                5'd8:  r = 32'sh0028BE53;
                5'd9:  r = 32'sh00145F2F;
                5'd10: r = 32'sh000A2F98;
                5'd11: r = 32'sh000517CC;
                5'd12: r = 32'sh00028BE6;
                5'd13: r = 32'sh000145F3;
                5'd14: r = 32'sh0000A2FA;
                5'd15: r = 32'sh0000517D;
                5'd16: r = 32'sh000028BE;
                5'd17: r = 32'sh0000145F;
                5'd18: r = 32'sh00000A30;
                5'd19: r = 32'sh00000518;
                5'd20: r = 32'sh0000028C;
                5'd21: r = 32'sh00000146;
                5'd22: r = 32'sh000000A3;
                5'd23: r = 32'sh00000051;
                5'd24: r = 32'sh00000029;
                5'd25: r = 32'sh00000014;
                5'd26: r = 32'sh0000000A;
                5'd27: r = 32'sh00000005;
                5'd28: r = 32'sh00000003;
                5'd29: r = 32'sh00000001;
                default: r = 32'sh00000000;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [39:0] v);
        logic signed [31:0] r;
        begin
            if (v > 40'sd1073741824) begin
                r = 32'sd1073741824;
            end
            else if (v < -40'sd1073741824) begin
                r = -32'sd1073741824;
            end
            else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

    function automatic op_t clamp_op(input op_t v);
        op_t r;
        begin
            if (v > Q30_ONE) begin
                r = Q30_ONE;
            end
            else if (v < -Q30_ONE) begin
                r = -Q30_ONE;
            end
            else begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

// ===== sv/axis_angle_matrix_rotation_core.sv =====
// Axis-angle (Rodrigues) rotation of Q16.16 points by a 3x3 Q2.30 matrix.
// Depends on aamr_pkg and axis_angle_matrix_rotation_core_macros.svh.
//
// The block rotates one point per clock cycle unless a low out_ready or a rebuild holds it,
// through its four-stage multiply, sum and round pipeline; stages that are empty keep
// accepting points while a finished result waits. Any configuration write rebuilds
// the rotation matrix with a sequencer that shares one multiplier, one bit-serial
// square root, one bit-serial divider and one iterative CORDIC unit; while the rebuild
// runs, in_ready and cfg_ready are low. An all-zero axis is treated as the x axis.
// Results are rounded to nearest and saturated, with saturated flagging any clipped
// component.
`include "axis_angle_matrix_rotation_core_macros.svh"

module axis_angle_matrix_rotation_core #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [((ANGLE_WIDTH > 16) ? ANGLE_WIDTH : 16)-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_WIDTH-1:0]  in_x,
    input  logic signed [COORD_WIDTH-1:0]  in_y,
    input  logic signed [COORD_WIDTH-1:0]  in_z,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [COORD_WIDTH-1:0]  out_x,
    output logic signed [COORD_WIDTH-1:0]  out_y,
    output logic signed [COORD_WIDTH-1:0]  out_z,
    output logic                           saturated
);

    localparam int PW     = (COORD_WIDTH > 25) ? COORD_WIDTH : 25;
    localparam int HW     = PW - 24;
    localparam int SUMW   = 59;
    localparam logic signed [SUMW-1:0] MAXV =
        {{(SUMW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SUMW-1:0] MINV = ~MAXV;
    localparam logic signed [SUMW-1:0] RND_HALF = 59'sd536870912;

    // Configuration and matrix state.
    logic signed [15:0]       axis_x_reg, axis_y_reg, axis_z_reg;
    logic [ANGLE_WIDTH-1:0]   angle_reg;
    logic signed [31:0]       mat_reg  [9];
    logic signed [31:0]       mat_next [9];

    // Rebuild sequencer.
    aamr_pkg::state_t  state_reg, state_next;
    logic [4:0]        step_reg, step_next;
    logic              phase_reg, phase_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [1:0]        div_idx_reg, div_idx_next;

    logic signed [67:0]   prod_reg, prod_next;
    logic signed [67:0]   acc_reg, acc_next;
    aamr_pkg::op_t        pair_reg [6];
    aamr_pkg::op_t        pair_next [6];
    aamr_pkg::op_t        nvec_reg [3];
    aamr_pkg::op_t        nvec_next [3];
    aamr_pkg::op_t        cos_reg, cos_next, sin_reg, sin_next;
    logic [61:0]          sq_x_reg, sq_x_next;
    logic [33:0]          sq_rem_reg, sq_rem_next;
    logic [30:0]          root_reg, root_next;
    logic [31:0]          dv_rem_reg, dv_rem_next;
    logic [31:0]          dv_lo_reg, dv_lo_next;
    logic [31:0]          quo_reg, quo_next;
    aamr_pkg::op_t        cx_reg, cx_next, cy_reg, cy_next;
    logic signed [31:0]   cz_reg, cz_next;

    logic                 cfg_we;
    logic                 axis_zero;
    logic signed [15:0]   ax_eff;
    aamr_pkg::mac_ctl_t   mac;
    aamr_pkg::op_t        t_val;
    logic signed [67:0]   acc_sum;
    logic signed [67:0]   rnd_full;
    logic signed [39:0]   rnd_w;
    logic signed [39:0]   mat_sum;

    logic [35:0]          sq_trial, sq_test;
    logic                 sq_ge;
    logic signed [15:0]   dv_axis;
    logic [15:0]          dv_mag;
    logic [60:0]          dv_num;
    logic [32:0]          dv_trial;
    logic                 dv_ge;
    logic [31:0]          dv_quo;
    logic [4:0]           cr_i;
    aamr_pkg::op_t        cr_x, cr_y, cr_xc, cr_yc;
    logic signed [31:0]   cr_z;
    logic [31:0]          phase32;

    assign cfg_ready = (state_reg == aamr_pkg::S_IDLE);
    assign cfg_we    = cfg_valid && cfg_ready;
    assign axis_zero = (axis_x_reg == 16'sd0) && (axis_y_reg == 16'sd0)
                       && (axis_z_reg == 16'sd0);
    assign ax_eff    = axis_zero ? 16'sd1 : axis_x_reg;
    assign t_val     = aamr_pkg::Q30_ONE - cos_reg;
    assign phase32   = {angle_reg, {(32-ANGLE_WIDTH){1'b0}}};

    // Multiply-accumulate program of a rebuild.
    always_comb
    begin
        mac.a    = '0;
        mac.b    = '0;
        mac.mode = aamr_pkg::ACC_LOAD;
        mac.dest = aamr_pkg::DST_NONE;
        mac.idx  = 4'd0;
        mac.base = '0;
        case (step_reg)
            5'd0:
            begin
                mac.a = aamr_pkg::OPW'(ax_eff);
                mac.b = aamr_pkg::OPW'(ax_eff);
            end
            5'd1:
            begin
                mac.a    = aamr_pkg::OPW'(axis_y_reg);
                mac.b    = aamr_pkg::OPW'(axis_y_reg);
                mac.mode = aamr_pkg::ACC_ADD;
            end
            5'd2:
            begin
                mac.a    = aamr_pkg::OPW'(axis_z_reg);
                mac.b    = aamr_pkg::OPW'(axis_z_reg);
                mac.mode = aamr_pkg::ACC_ADD;
                mac.dest = aamr_pkg::DST_LEN;
            end
            5'd3:
            begin
                mac.a = nvec_reg[0]; mac.b = nvec_reg[0];
                mac.dest = aamr_pkg::DST_PAIR; mac.idx = 4'd0;
            end
            5'd4:
            begin
                mac.a = nvec_reg[1]; mac.b = nvec_reg[1];
                mac.dest = aamr_pkg::DST_PAIR; mac.idx = 4'd1;
            end
            5'd5:
            begin
                mac.a = nvec_reg[2]; mac.b = nvec_reg[2];
                mac.dest = aamr_pkg::DST_PAIR; mac.idx = 4'd2;
            end
            5'd6:
            begin
                mac.a = nvec_reg[0]; mac.b = nvec_reg[1];
                mac.dest = aamr_pkg::DST_PAIR; mac.idx = 4'd3;
            end
            5'd7:
            begin
                mac.a = nvec_reg[0]; mac.b = nvec_reg[2];
                mac.dest = aamr_pkg::DST_PAIR; mac.idx = 4'd4;
            end
            5'd8:
            begin
                mac.a = nvec_reg[1]; mac.b = nvec_reg[2];
                mac.dest = aamr_pkg::DST_PAIR; mac.idx = 4'd5;
            end
            5'd9:
            begin
                mac.a = pair_reg[1] + pair_reg[2]; mac.b = cos_reg;
                mac.dest = aamr_pkg::DST_MAT; mac.idx = 4'd0; mac.base = pair_reg[0];
            end
            5'd10:
            begin
                mac.a = pair_reg[0] + pair_reg[2]; mac.b = cos_reg;
                mac.dest = aamr_pkg::DST_MAT; mac.idx = 4'd4; mac.base = pair_reg[1];
            end
            5'd11:
            begin
                mac.a = pair_reg[0] + pair_reg[1]; mac.b = cos_reg;
                mac.dest = aamr_pkg::DST_MAT; mac.idx = 4'd8; mac.base = pair_reg[2];
            end
            5'd12:
            begin
                mac.a = pair_reg[3]; mac.b = t_val;
            end
            5'd13:
            begin
                mac.a = nvec_reg[2]; mac.b = sin_reg; mac.mode = aamr_pkg::ACC_SUB;
                mac.dest = aamr_pkg::DST_MAT; mac.idx = 4'd1;
            end
            5'd14:
            begin
                mac.a = pair_reg[4]; mac.b = t_val;
            end
            5'd15:
            begin
                mac.a = nvec_reg[1]; mac.b = sin_reg; mac.mode = aamr_pkg::ACC_ADD;
                mac.dest = aamr_pkg::DST_MAT; mac.idx = 4'd2;
            end
            5'd16:
            begin
                mac.a = pair_reg[3]; mac.b = t_val;
            end
            5'd17:
            begin
                mac.a = nvec_reg[2]; mac.b = sin_reg; mac.mode = aamr_pkg::ACC_ADD;
                mac.dest = aamr_pkg::DST_MAT; mac.idx = 4'd3;
            end
            5'd18:
            begin
                mac.a = pair_reg[5]; mac.b = t_val;
            end
            5'd19:
            begin
                mac.a = nvec_reg[0]; mac.b = sin_reg; mac.mode = aamr_pkg::ACC_SUB;
                mac.dest = aamr_pkg::DST_MAT; mac.idx = 4'd5;
            end
            5'd20:
            begin
                mac.a = pair_reg[4]; mac.b = t_val;
            end
            5'd21:
            begin
                mac.a = nvec_reg[1]; mac.b = sin_reg; mac.mode = aamr_pkg::ACC_SUB;
                mac.dest = aamr_pkg::DST_MAT; mac.idx = 4'd6;
            end
            5'd22:
            begin
                mac.a = pair_reg[5]; mac.b = t_val;
            end
            5'd23:
            begin
                mac.a = nvec_reg[0]; mac.b = sin_reg; mac.mode = aamr_pkg::ACC_ADD;
                mac.dest = aamr_pkg::DST_MAT; mac.idx = 4'd7;
            end
            default:
            begin
                mac.a = '0;
            end
        endcase
    end

    always_comb
    begin
        case (mac.mode)
            aamr_pkg::ACC_ADD: acc_sum = acc_reg + prod_reg;
            aamr_pkg::ACC_SUB: acc_sum = acc_reg - prod_reg;
            default:           acc_sum = prod_reg;
        endcase
        rnd_full = (acc_sum + 68'sd536870912) >>> 30;
        rnd_w    = rnd_full[39:0];
        mat_sum  = 40'(mac.base) + rnd_w;
    end

    // Square root, division and CORDIC step logic.
    always_comb
    begin
        sq_trial = {sq_rem_reg, sq_x_reg[61:60]};
        sq_test  = {3'b000, root_reg, 2'b01};
        sq_ge    = (sq_trial >= sq_test);

        case (div_idx_reg)
            2'd0:    dv_axis = ax_eff;
            2'd1:    dv_axis = axis_y_reg;
            default: dv_axis = axis_z_reg;
        endcase
        dv_mag   = dv_axis[15] ? 16'(-dv_axis) : dv_axis;
        dv_num   = {dv_mag, 45'd0} + 61'(root_reg[30:1]);
        dv_trial = {dv_rem_reg, dv_lo_reg[31]};
        dv_ge    = (dv_trial >= {2'b00, root_reg});
        dv_quo   = {quo_reg[30:0], dv_ge};

        cr_i = 5'(cnt_reg - 6'd1);
        if (!cz_reg[31])
        begin
            cr_x = cx_reg - (cy_reg >>> cr_i);
            cr_y = cy_reg + (cx_reg >>> cr_i);
            cr_z = cz_reg - aamr_pkg::atan_turn(cr_i);
        end
        else
        begin
            cr_x = cx_reg + (cy_reg >>> cr_i);
            cr_y = cy_reg - (cx_reg >>> cr_i);
            cr_z = cz_reg + aamr_pkg::atan_turn(cr_i);
        end
        cr_xc = aamr_pkg::clamp_op(cr_x);
        cr_yc = aamr_pkg::clamp_op(cr_y);
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        div_idx_next = div_idx_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        pair_next    = pair_reg;
        nvec_next    = nvec_reg;
        cos_next     = cos_reg;
        sin_next     = sin_reg;
        mat_next     = mat_reg;
        sq_x_next    = sq_x_reg;
        sq_rem_next  = sq_rem_reg;
        root_next    = root_reg;
        dv_rem_next  = dv_rem_reg;
        dv_lo_next   = dv_lo_reg;
        quo_next     = quo_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        case (state_reg)
            aamr_pkg::S_IDLE:
            begin
                if (cfg_we)
                begin
                    state_next = aamr_pkg::S_LEN;
                    step_next  = 5'd0;
                    phase_next = 1'b0;
                end
            end
            aamr_pkg::S_LEN, aamr_pkg::S_MAT:
            begin
                if (!phase_reg)
                begin
                    prod_next  = mac.a * mac.b;
                    phase_next = 1'b1;
                end
                else
                begin
                    acc_next   = acc_sum;
                    phase_next = 1'b0;
                    step_next  = step_reg + 5'd1;
                    case (mac.dest)
                        aamr_pkg::DST_LEN:
                        begin
                            sq_x_next   = {acc_sum[31:0], 30'd0};
                            sq_rem_next = '0;
                            root_next   = '0;
                            cnt_next    = '0;
                            state_next  = aamr_pkg::S_SQRT;
                        end
                        aamr_pkg::DST_PAIR:
                        begin
                            pair_next[mac.idx[2:0]] = rnd_w[33:0];
                        end
                        aamr_pkg::DST_MAT:
                        begin
                            mat_next[mac.idx] = aamr_pkg::clamp_q30(mat_sum);
                        end
                        default:
                        begin
                            acc_next = acc_sum;
                        end
                    endcase
                    if (step_reg == 5'(aamr_pkg::MAC_LAST))
                    begin
                        state_next = aamr_pkg::S_IDLE;
                    end
                end
            end
            aamr_pkg::S_SQRT:
            begin
                sq_x_next   = {sq_x_reg[59:0], 2'b00};
                sq_rem_next = sq_ge ? 34'(sq_trial - sq_test) : sq_trial[33:0];
                root_next   = {root_reg[29:0], sq_ge};
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'(aamr_pkg::SQRT_ITERS - 1))
                begin
                    cnt_next     = '0;
                    div_idx_next = 2'd0;
                    state_next   = aamr_pkg::S_DIV;
                end
            end
            aamr_pkg::S_DIV:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    dv_rem_next = {3'b000, dv_num[60:32]};
                    dv_lo_next  = dv_num[31:0];
                    quo_next    = '0;
                end
                else
                begin
                    dv_rem_next = dv_ge ? 32'(dv_trial - {2'b00, root_reg}) : dv_trial[31:0];
                    dv_lo_next  = {dv_lo_reg[30:0], 1'b0};
                    quo_next    = dv_quo;
                    if (cnt_reg == 6'(aamr_pkg::DIV_ITERS))
                    begin
                        nvec_next[div_idx_reg] = dv_axis[15]
                            ? -aamr_pkg::OPW'({2'b00, dv_quo})
                            : aamr_pkg::OPW'({2'b00, dv_quo});
                        cnt_next = '0;
                        if (div_idx_reg == 2'd2)
                        begin
                            state_next = aamr_pkg::S_CORDIC;
                        end
                        else
                        begin
                            div_idx_next = div_idx_reg + 2'd1;
                        end
                    end
                end
            end
            aamr_pkg::S_CORDIC:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    cx_next = aamr_pkg::CORDIC_START;
                    cy_next = '0;
                    cz_next = {2'b00, phase32[29:0]};
                end
                else
                begin
                    cx_next = cr_x;
                    cy_next = cr_y;
                    cz_next = cr_z;
                    if (cnt_reg == 6'(aamr_pkg::CORDIC_STEPS))
                    begin
                        case (phase32[31:30])
                            2'd0:
                            begin
                                cos_next = cr_xc;
                                sin_next = cr_yc;
                            end
                            2'd1:
                            begin
                                cos_next = -cr_yc;
                                sin_next = cr_xc;
                            end
                            2'd2:
                            begin
                                cos_next = -cr_xc;
                                sin_next = -cr_yc;
                            end
                            default:
                            begin
                                cos_next = cr_yc;
                                sin_next = -cr_xc;
                            end
                        endcase
                        cnt_next   = '0;
                        step_next  = 5'(aamr_pkg::MAC_FIRST_MAT);
                        phase_next = 1'b0;
                        state_next = aamr_pkg::S_MAT;
                    end
                end
            end
            default:
            begin
                state_next = aamr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= aamr_pkg::S_IDLE;
            step_reg    <= '0;
            phase_reg   <= 1'b0;
            cnt_reg     <= '0;
            div_idx_reg <= '0;
            axis_x_reg  <= 16'sd1;
            axis_y_reg  <= 16'sd0;
            axis_z_reg  <= 16'sd0;
            angle_reg   <= '0;
            for (int i = 0; i < 9; i++)
            begin
                mat_reg[i] <= (i % 4 == 0) ? 32'sd1073741824 : 32'sd0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            div_idx_reg <= div_idx_next;
            mat_reg     <= mat_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    aamr_pkg::CFG_AXIS_X: axis_x_reg <= cfg_data[15:0];
                    aamr_pkg::CFG_AXIS_Y: axis_y_reg <= cfg_data[15:0];
                    aamr_pkg::CFG_AXIS_Z: axis_z_reg <= cfg_data[15:0];
                    aamr_pkg::CFG_ANGLE:  angle_reg  <= cfg_data[ANGLE_WIDTH-1:0];
                    default:              angle_reg  <= angle_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        pair_reg   <= pair_next;
        nvec_reg   <= nvec_next;
        cos_reg    <= cos_next;
        sin_reg    <= sin_next;
        sq_x_reg   <= sq_x_next;
        sq_rem_reg <= sq_rem_next;
        root_reg   <= root_next;
        dv_rem_reg <= dv_rem_next;
        dv_lo_reg  <= dv_lo_next;
        quo_reg    <= quo_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
    end

    // Point pipeline: split, multiply, sum, round and saturate.
    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic                        v1_next, v2_next, v3_next, v4_next;
    logic                        rdy1, rdy2, rdy3, rdy4;
    logic signed [PW-1:0]        pe [3];
    logic signed [HW-1:0]        hi_reg [3];
    logic signed [HW-1:0]        hi_next [3];
    logic [23:0]                 lo_reg [3];
    logic [23:0]                 lo_next [3];
    logic signed [31+HW:0]       ph_reg [9];
    logic signed [31+HW:0]       ph_next [9];
    logic signed [56:0]          pl_reg [9];
    logic signed [56:0]          pl_next [9];
    logic signed [SUMW-1:0]      shi_reg [3];
    logic signed [SUMW-1:0]      shi_next [3];
    logic signed [SUMW-1:0]      slo_reg [3];
    logic signed [SUMW-1:0]      slo_next [3];
    logic signed [SUMW-1:0]      vsum [3];
    logic signed [COORD_WIDTH-1:0] res_next [3];
    logic [2:0]                  clip;
    logic signed [COORD_WIDTH-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                        sat_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1 && (state_reg == aamr_pkg::S_IDLE);

    assign v1_next = rdy1 ? (in_valid && in_ready) : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;
    assign v4_next = rdy4 ? v3_reg : v4_reg;

    always_comb
    begin
        pe[0] = PW'(in_x);
        pe[1] = PW'(in_y);
        pe[2] = PW'(in_z);
        for (int k = 0; k < 3; k++)
        begin
            hi_next[k] = pe[k][PW-1:24];
            lo_next[k] = pe[k][23:0];
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ph_next[r*3+k] = mat_reg[r*3+k] * hi_reg[k];
                pl_next[r*3+k] = mat_reg[r*3+k] * $signed({1'b0, lo_reg[k]});
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            shi_next[r] = SUMW'(ph_reg[r*3]) + SUMW'(ph_reg[r*3+1])
                          + SUMW'(ph_reg[r*3+2]);
            slo_next[r] = SUMW'(pl_reg[r*3]) + SUMW'(pl_reg[r*3+1])
                          + SUMW'(pl_reg[r*3+2]) + RND_HALF;
        end
        for (int r = 0; r < 3; r++)
        begin
            vsum[r] = (shi_reg[r] + (slo_reg[r] >>> 24)) >>> 6;
            if (vsum[r] > MAXV)
            begin
                res_next[r] = MAXV[COORD_WIDTH-1:0];
                clip[r]     = 1'b1;
            end
            else if (vsum[r] < MINV)
            begin
                res_next[r] = MINV[COORD_WIDTH-1:0];
                clip[r]     = 1'b1;
            end
            else
            begin
                res_next[r] = vsum[r][COORD_WIDTH-1:0];
                clip[r]     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
        if (rdy2)
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
        end
        if (rdy3)
        begin
            shi_reg <= shi_next;
            slo_reg <= slo_next;
        end
        if (rdy4)
        begin
            out_x_reg <= res_next[0];
            out_y_reg <= res_next[1];
            out_z_reg <= res_next[2];
            sat_reg   <= |clip;
        end
    end

    assign out_valid = v4_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign saturated = sat_reg;

    logic mat_ok;

    always_comb
    begin
        mat_ok = 1'b1;
        for (int i = 0; i < 9; i++)
        begin
            if ((mat_reg[i] > 32'sd1073741824) || (mat_reg[i] < -32'sd1073741824))
            begin
                mat_ok = 1'b0;
            end
        end
    end

    `AAMR_ASSERT_NEXT(a_cfg_starts_rebuild, cfg_valid && cfg_ready, state_reg == aamr_pkg::S_LEN, "config write did not start a rebuild")
    `AAMR_ASSERT_NOW(a_rebuild_blocks, state_reg != aamr_pkg::S_IDLE, !in_ready && !cfg_ready, "port open during rebuild")
    `AAMR_ASSERT_NEXT(a_stage_holds, v3_reg && !rdy4, v3_reg, "stalled pipeline beat lost")
    `AAMR_ASSERT_NOW(a_matrix_range, 1'b1, mat_ok, "matrix entry outside unit range")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for axis_angle_matrix_rotation_core.
// Depends on aamr_pkg; rebuilds the rotation matrix and rotates each point in its own
// fixed-point predictor, then checks every output beat against the oldest prediction.
module testbench;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } rotated_t;

    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam longint ARCTAN_TURNS [0:29] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [15:0]         cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic signed [31:0]  in_x;
    logic signed [31:0]  in_y;
    logic signed [31:0]  in_z;
    logic                out_valid;
    logic                out_ready;
    logic signed [31:0]  out_x;
    logic signed [31:0]  out_y;
    logic signed [31:0]  out_z;
    logic                saturated;

    point_t   pending_points[$];
    rotated_t expected_points[$];
    longint   matrix[9];
    logic signed [15:0] axis_reg[3];
    logic [15:0]        angle_reg;
    int       error_count;
    int       in_gap;
    int       out_gap;
    bit       in_fire;
    bit       no_idle;

    axis_angle_matrix_rotation_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .saturated (saturated)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > ONE_Q30)
        begin
            return ONE_Q30;
        end
        if (v < -ONE_Q30)
        begin
            return -ONE_Q30;
        end
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unit_component(longint a, longint unsigned r);
        longint unsigned mag;
        longint q;
        mag = (a < 0) ? -a : a;
        q = ((mag << 45) + (r >> 1)) / r;
        return (a < 0) ? -q : q;
    endfunction

    task automatic cordic_sin_cos(output longint c, output longint s);
        logic [31:0] phase;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        phase = {angle_reg, 16'h0000};
        x = 64'sd652032874;
        y = 0;
        z = phase[29:0];
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_TURNS[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_TURNS[i];
            end
        end
        x = clamp_unit(x);
        y = clamp_unit(y);
        case (phase[31:30])
            2'd0:
            begin
                c = x;
                s = y;
            end
            2'd1:
            begin
                c = -y;
                s = x;
            end
            2'd2:
            begin
                c = -x;
                s = -y;
            end
            default:
            begin
                c = y;
                s = -x;
            end
        endcase
    endtask

    task automatic rebuild_matrix();
        longint ax, ay, az, c, s, t, nx, ny, nz, xx, yy, zz, xy, xz, yz;
        longint unsigned r;
        ax = axis_reg[0];
        ay = axis_reg[1];
        az = axis_reg[2];
        if (ax == 0 && ay == 0 && az == 0)
        begin
            ax = 1;
        end
        r = int_sqrt(longint'(ax * ax + ay * ay + az * az) << 30);
        nx = unit_component(ax, r);
        ny = unit_component(ay, r);
        nz = unit_component(az, r);
        cordic_sin_cos(c, s);
        t = ONE_Q30 - c;
        xx = round_q30(nx * nx);
        yy = round_q30(ny * ny);
        zz = round_q30(nz * nz);
        xy = round_q30(nx * ny);
        xz = round_q30(nx * nz);
        yz = round_q30(ny * nz);
        matrix[0] = xx + round_q30((yy + zz) * c);
        matrix[1] = round_q30(xy * t - nz * s);
        matrix[2] = round_q30(xz * t + ny * s);
        matrix[3] = round_q30(xy * t + nz * s);
        matrix[4] = yy + round_q30((xx + zz) * c);
        matrix[5] = round_q30(yz * t - nx * s);
        matrix[6] = round_q30(xz * t - ny * s);
        matrix[7] = round_q30(yz * t + nx * s);
        matrix[8] = zz + round_q30((xx + yy) * c);
        for (int i = 0; i < 9; i++)
        begin
            matrix[i] = clamp_unit(matrix[i]);
        end
    endtask

    function automatic rotated_t rotate_point(point_t p);
        longint coord[3];
        longint hi[3];
        longint lo[3];
        longint shi;
        longint slo;
        longint v;
        rotated_t r;
        coord[0] = p.x;
        coord[1] = p.y;
        coord[2] = p.z;
        r.sat = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            hi[k] = coord[k] >>> 24;
            lo[k] = coord[k] - hi[k] * (64'sd1 << 24);
        end
        for (int i = 0; i < 3; i++)
        begin
            shi = 0;
            slo = 64'sd1 << 29;
            for (int k = 0; k < 3; k++)
            begin
                shi = shi + matrix[i * 3 + k] * hi[k];
                slo = slo + matrix[i * 3 + k] * lo[k];
            end
            v = (shi + (slo >>> 24)) >>> 6;
            if (v > 64'sd2147483647)
            begin
                v = 64'sd2147483647;
                r.sat = 1'b1;
            end
            if (v < -64'sd2147483648)
            begin
                v = -64'sd2147483648;
                r.sat = 1'b1;
            end
            case (i)
                0: r.x = v[31:0];
                1: r.y = v[31:0];
                default: r.z = v[31:0];
            endcase
        end
        return r;
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] random_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return $urandom;
        end
        if (r < 85)
        begin
            return $signed($urandom_range(0, 32'h003FFFFF)) - 32'sh00200000;
        end
        case ($urandom_range(0, 3))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sh00010000;
            default: return -32'sh00010000;
        endcase
    endfunction

    task automatic push_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        pending_points.push_back(p);
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || expected_points.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == aamr_pkg::CFG_ANGLE)
        begin
            angle_reg = value;
        end
        else
        begin
            axis_reg[idx] = value;
        end
        rebuild_matrix();
    endtask

    task automatic directed_points();
        push_point(0, 0, 0);
        push_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        push_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
        push_point(32'sh7FFFFFFF, 32'sh80000000, 0);
        push_point(32'sh00010000, -32'sh00010000, 32'sh00008000);
        push_point(1, -1, 32'sh00FFFFFF);
        push_point(32'shFF000000, 32'sh01000000, -32'sh00000001);
    endtask

    initial
    begin
        logic [15:0] value;
        error_count = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = aamr_pkg::CFG_AXIS_X;
        cfg_data = '0;
        in_valid = 1'b0;
        in_x = '0;
        in_y = '0;
        in_z = '0;
        out_ready = 1'b0;
        no_idle = 1'b0;
        axis_reg[0] = 16'sd1;
        axis_reg[1] = 16'sd0;
        axis_reg[2] = 16'sd0;
        angle_reg = 16'd0;
        for (int i = 0; i < 9; i++)
        begin
            matrix[i] = (i % 4 == 0) ? ONE_Q30 : 0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Exact identity after reset, then a zero axis (taken as x) and a right angle about it.
        directed_points();
        wait_drained();
        write_register(aamr_pkg::CFG_AXIS_X, 16'h0000);
        write_register(aamr_pkg::CFG_ANGLE, 16'h4000);
        directed_points();
        wait_drained();
        write_register(aamr_pkg::CFG_AXIS_Z, 16'h7FFF);
        write_register(aamr_pkg::CFG_ANGLE, 16'h2000);
        directed_points();
        wait_drained();
        write_register(aamr_pkg::CFG_AXIS_X, 16'h8000);
        write_register(aamr_pkg::CFG_AXIS_Y, 16'h8000);
        write_register(aamr_pkg::CFG_AXIS_Z, 16'h8000);
        write_register(aamr_pkg::CFG_ANGLE, 16'hFFFF);
        directed_points();

        for (int phase_idx = 0; phase_idx < 12; phase_idx++)
        begin
            wait_drained();
            no_idle = (phase_idx % 4 == 3);
            for (int reg_idx = 0; reg_idx < 4; reg_idx++)
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    case ($urandom_range(0, 5))
                        0: value = 16'h0000;
                        1: value = 16'h7FFF;
                        2: value = 16'h8000;
                        3: value = 16'hFFFF;
                        4: value = 16'($urandom_range(0, 15)) - 16'd8;
                        default: value = 16'($urandom);
                    endcase
                    write_register(reg_idx[1:0], value);
                end
            end
            for (int n = 0; n < 70; n++)
            begin
                push_point(random_coord(), random_coord(), random_coord());
            end
        end
        wait_drained();
        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    always @(posedge clk)
    begin
        rotated_t want;
        point_t   p;
        in_fire <= in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            p.x = in_x;
            p.y = in_y;
            p.z = in_z;
            expected_points.push_back(rotate_point(p));
        end
        if (out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected beat x=%0d y=%0d z=%0d sat=%0b",
                         $time, out_x, out_y, out_z, saturated);
                error_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (out_x !== want.x || out_y !== want.y || out_z !== want.z
                    || saturated !== want.sat)
                begin
                    $display("%0t: expected x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                             $time, want.x, want.y, want.z, want.sat,
                             out_x, out_y, out_z, saturated);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        point_t p;
        if (!rst_n)
        begin
            in_gap = 0;
            out_gap = 0;
        end
        else
        begin
            if (!in_valid || in_fire)
            begin
                if (in_gap > 0 || pending_points.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (in_gap > 0)
                    begin
                        in_gap--;
                    end
                end
                else
                begin
                    p = pending_points.pop_front();
                    in_valid <= 1'b1;
                    in_x <= p.x;
                    in_y <= p.y;
                    in_z <= p.z;
                    in_gap = random_gap();
                end
            end
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap = random_gap();
            end
        end
    end

    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end
endmodule
